// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/itw_pkg.sv -----
`timescale 1ns / 1ps
package itw_pkg;

  localparam int VALUE_W = 32;
  localparam int CODE_W  = 6;
  localparam int DIGITS  = 12;
  localparam int BCD_W   = DIGITS * 4;

  // Token codes
  localparam logic [CODE_W-1:0] TOK_ZERO     = 6'd0;
  localparam logic [CODE_W-1:0] TOK_TEN      = 6'd10;
  localparam logic [CODE_W-1:0] TOK_TENS_OFS = 6'd18;
  localparam logic [CODE_W-1:0] TOK_HUNDRED  = 6'd28;
  localparam logic [CODE_W-1:0] TOK_NEGATIVE = 6'd32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_ZERO,
    ST_HDIG,
    ST_HUND,
    ST_TENS,
    ST_ONES,
    ST_SCALE
  } itw_state_t;

endpackage

// ----- rtl/integer_to_word_tokens.sv -----
`timescale 1ns / 1ps
// Channel  | Direction | Ports
// ---------+-----------+--------------------------------------------
// in       | input     | in_valid, in_ready, in_value[31:0] signed
// out      | output    | out_valid, out_ready, out_word_code[5:0], out_last_word
//
// One value is accepted, then converted by shift-and-add-3 BCD (one magnitude
// bit per cycle), then a sequencer walks up to four three-digit groups, one step
// per cycle while no token waits on a stalled output, one token at most per step.
// in_ready is high only while the sequencer is idle; a stalled output register
// holds the sequencer. Synchronous active-low reset returns to idle, output empty.
module integer_to_word_tokens (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [itw_pkg::VALUE_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itw_pkg::CODE_W-1:0]    out_word_code,
  output logic                          out_last_word
);
  import itw_pkg::*;

  itw_state_t          state_r, state_nxt;
  logic [VALUE_W-1:0]  shreg_r, shreg_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [BCD_W-1:0]    adj;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [1:0]          grp_cnt_r, grp_cnt_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]   out_code_r, out_code_nxt;
  logic                out_last_r, out_last_nxt;

  logic                emit;
  logic [CODE_W-1:0]   emit_code;
  logic                emit_last;
  logic                slot_free;
  logic                go;
  logic [11:0]         grp;
  logic [3:0]          dig_h, dig_t, dig_o;
  logic                lower_zero;
  logic                conv_last;

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_word_code = out_code_r;
  assign out_last_word = out_last_r;

  assign slot_free  = !out_valid_r || out_ready;
  assign grp        = bcd_r[BCD_W-1 -: 12];
  assign dig_h      = grp[11:8];
  assign dig_t      = grp[7:4];
  assign dig_o      = grp[3:0];
  assign lower_zero = (bcd_r[BCD_W-13:0] == '0);
  assign conv_last  = (state_r == ST_CONV) && (cnt_r == 5'd31);

  // Add 3 to every BCD digit of five or more before the next shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                 : bcd_r[i*4 +: 4];
    end
  end

  // Next state, datapath and token selection
  always_comb begin
    state_nxt   = state_r;
    shreg_nxt   = shreg_r;
    bcd_nxt     = bcd_r;
    cnt_nxt     = cnt_r;
    grp_cnt_nxt = grp_cnt_r;
    neg_nxt     = neg_r;
    emit        = 1'b0;
    emit_code   = TOK_ZERO;
    emit_last   = 1'b0;
    go          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          shreg_nxt   = in_value[VALUE_W-1] ? VALUE_W'(32'd0 - in_value) : in_value;
          bcd_nxt     = '0;
          neg_nxt     = in_value[VALUE_W-1];
          cnt_nxt     = '0;
          grp_cnt_nxt = 2'd3;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        {bcd_nxt, shreg_nxt} = {adj, shreg_r} << 1;
        cnt_nxt = cnt_r + 5'd1;
        if (conv_last) state_nxt = ST_SIGN;
      end
      ST_SIGN: begin
        emit      = neg_r;
        emit_code = TOK_NEGATIVE;
        go        = !emit || slot_free;
        if (go) state_nxt = (bcd_r == '0) ? ST_ZERO : ST_HDIG;
      end
      ST_ZERO: begin
        emit      = 1'b1;
        emit_code = TOK_ZERO;
        emit_last = 1'b1;
        go        = slot_free;
        if (go) state_nxt = ST_IDLE;
      end
      ST_HDIG: begin
        if (grp == '0) begin
          // skip an empty group, scale word included
          if (grp_cnt_r == 2'd0) begin
            state_nxt = ST_IDLE;
          end else begin
            bcd_nxt     = {bcd_r[BCD_W-13:0], 12'd0};
            grp_cnt_nxt = grp_cnt_r - 2'd1;
          end
        end else begin
          emit      = (dig_h != 4'd0);
          emit_code = {2'b00, dig_h};
          go        = !emit || slot_free;
          if (go) state_nxt = emit ? ST_HUND : ST_TENS;
        end
      end
      ST_HUND: begin
        emit      = 1'b1;
        emit_code = TOK_HUNDRED;
        emit_last = (dig_t == 4'd0) && (dig_o == 4'd0) && (grp_cnt_r == 2'd0);
        go        = slot_free;
        if (go) state_nxt = ST_TENS;
      end
      ST_TENS: begin
        if (dig_t >= 4'd2) begin
          emit      = 1'b1;
          emit_code = TOK_TENS_OFS + {2'b00, dig_t};
          emit_last = (dig_o == 4'd0) && (grp_cnt_r == 2'd0);
        end else if (dig_t == 4'd1) begin
          emit      = 1'b1;
          emit_code = TOK_TEN + {2'b00, dig_o};
          emit_last = (grp_cnt_r == 2'd0);
        end else begin
          emit      = (dig_o != 4'd0);
          emit_code = {2'b00, dig_o};
          emit_last = (grp_cnt_r == 2'd0);
        end
        go = !emit || slot_free;
        if (go) state_nxt = (dig_t >= 4'd2) ? ST_ONES : ST_SCALE;
      end
      ST_ONES: begin
        emit      = (dig_o != 4'd0);
        emit_code = {2'b00, dig_o};
        emit_last = (grp_cnt_r == 2'd0);
        go        = !emit || slot_free;
        if (go) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (grp_cnt_r == 2'd0) begin
          state_nxt = ST_IDLE;
        end else begin
          emit      = 1'b1;
          emit_code = TOK_HUNDRED + {4'd0, grp_cnt_r};
          emit_last = lower_zero;
          go        = slot_free;
          if (go) begin
            if (lower_zero) begin
              state_nxt = ST_IDLE;
            end else begin
              bcd_nxt     = {bcd_r[BCD_W-13:0], 12'd0};
              grp_cnt_nxt = grp_cnt_r - 2'd1;
              state_nxt   = ST_HDIG;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Load the output register on a token, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    if (emit && slot_free) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = emit_code;
      out_last_nxt  = emit_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    shreg_r    <= shreg_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    grp_cnt_r  <= grp_cnt_nxt;
    neg_r      <= neg_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

`include "assert_macros.svh"

  `ASSERT_HOLDS(a_code_range, out_valid_r |-> (out_code_r <= TOK_NEGATIVE), "bad token code")
  `ASSERT_HOLDS(a_top_digits, (state_r == ST_SIGN) |-> (bcd_r[47:40] == '0), "top digits set")
  `ASSERT_NEVER(a_idle_emit, (in_ready || (state_r == ST_CONV)) && emit, "early token")
  `ASSERT_HOLDS(a_conv_done, conv_last |=> (state_r == ST_SIGN), "conversion length")

endmodule
